// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/hhve_pkg.sv =====
// types, constants and per-byte step functions of the header value extractor
package hhve_pkg;

  localparam int DEF_MAX_NAME_BYTES = 16;
  localparam int DEF_LENGTH_BITS    = 16;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [31:0] BLANK_LINE = {CH_CR, CH_LF, CH_CR, CH_LF};

  localparam logic [1:0] REG_NAME_LOW  = 2'd0;
  localparam logic [1:0] REG_NAME_HIGH = 2'd1;
  localparam logic [1:0] REG_NAME_LEN  = 2'd2;

  typedef enum logic [6:0] {
    PH_SEARCH    = 7'b0000001,
    PH_COLON     = 7'b0000010,
    PH_SPACE     = 7'b0000100,
    PH_VALUE     = 7'b0001000,
    PH_DONE      = 7'b0010000,
    PH_COLON_END = 7'b0100000,
    PH_SPACE_END = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_BYTE     = 2'd1,
    ST_COMPLETE = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  match_count;
    logic [31:0] recent;
    status_t     status;
  } step_t;

  // one byte through the naive name matcher
  function automatic step_t search_step(input step_t s, input logic [7:0] b,
                                        input logic [127:0] name, input logic [4:0] len);
    step_t      r;
    logic [4:0] mc1;
    logic       hit;
    r = s;
    r.status = ST_IDLE;
    mc1 = s.match_count + 5'd1;
    hit = (s.match_count < len) && (b == name[{s.match_count[3:0], 3'b000} +: 8]);
    if (b == CH_NUL) begin
      r.phase = PH_DONE;
      r.status = ST_NOTFOUND;
    end else begin
      r.recent = {s.recent[23:0], b};
      if (hit && (mc1 == len)) begin
        r.match_count = 5'd0;
        r.phase = (r.recent == BLANK_LINE) ? PH_COLON_END : PH_COLON;
      end else begin
        r.match_count = hit ? mc1 : 5'd0;
        if (r.recent == BLANK_LINE) begin
          r.phase = PH_DONE;
          r.status = ST_NOTFOUND;
        end
      end
    end
    return r;
  endfunction

  function automatic step_t colon_step(input step_t s, input logic [7:0] b,
                                       input logic [127:0] name, input logic [4:0] len);
    step_t r;
    step_t t;
    logic  at_end;
    at_end = (s.phase == PH_COLON_END);
    r = s;
    r.status = ST_IDLE;
    t = s;
    t.phase = PH_SEARCH;
    if (b == CH_COLON) begin
      r.phase = at_end ? PH_SPACE_END : PH_SPACE;
    end else if (at_end) begin
      r.phase = PH_DONE;
      r.status = ST_NOTFOUND;
    end else begin
      r = search_step(t, b, name, len);
    end
    return r;
  endfunction

  // missing space: the held colon is searched, then the current byte
  function automatic step_t space_step(input step_t s, input logic [7:0] b,
                                       input logic [127:0] name, input logic [4:0] len);
    step_t r;
    step_t t;
    r = s;
    r.status = ST_IDLE;
    t = s;
    t.phase = PH_SEARCH;
    if (b == CH_SPACE) begin
      r.phase = PH_VALUE;
    end else if (s.phase == PH_SPACE_END) begin
      r.phase = PH_DONE;
      r.status = ST_NOTFOUND;
    end else begin
      t = search_step(t, CH_COLON, name, len);
      if (t.phase == PH_DONE) begin
        r = t;
      end else if ((t.phase == PH_COLON) || (t.phase == PH_COLON_END)) begin
        r = colon_step(t, b, name, len);
      end else begin
        r = search_step(t, b, name, len);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/http_header_value_extractor.sv =====
// http header value extractor: byte-per-cycle name search and value output
//
// channel   dir  fields (lsb first)                         handshake
// s_*       in   tdata: data_byte[7:0]; tuser: start_of_request  tvalid/tready
// m_*       out  tdata: value_byte[7:0], value_length[23:8];
//                tuser: status[1:0]                         tvalid/tready
// apb       in   name_bytes_low @0, name_bytes_high @8, name_length @16
//
// one byte per cycle while s_tready is high; each request gives exactly one result, in the next cycle
// search state updates at the accept edge, the result register holds the output
// s_tready is low only while a result waits and m_tready is low
// rst is synchronous and returns to searching with name_length 1
`include "assert_macros.svh"

module http_header_value_extractor
  import hhve_pkg::*;
#(
  parameter int MAX_NAME_BYTES = DEF_MAX_NAME_BYTES,
  parameter int LENGTH_BITS    = DEF_LENGTH_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic [0:0]  s_tuser,   // start_of_request[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // value_byte[7:0], value_length[23:8]
  output logic [1:0]  m_tuser,   // status[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int LW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  logic [63:0] name_bytes_low;
  logic [63:0] name_bytes_high;
  logic [4:0]  name_length;

  phase_t                 phase;
  logic [4:0]             match_count;
  logic [31:0]            recent;
  logic [LENGTH_BITS-1:0] value_count;

  logic                   s_accept;
  logic [4:0]             len_use;
  step_t                  s0;
  step_t                  r;
  logic [LENGTH_BITS-1:0] vc0;
  logic [LENGTH_BITS-1:0] value_count_next;
  logic [LENGTH_BITS-1:0] vlen_src;
  logic [LW-1:0]          vlen_wide;
  logic [15:0]            vlen;
  logic [7:0]             vbyte;
  logic [7:0]             b;

  assign pready = 1'b1;
  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;
  assign b = s_tdata;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      name_bytes_low <= '0;
      name_bytes_high <= '0;
      name_length <= 5'd1;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:3])
        REG_NAME_LOW:  name_bytes_low <= pwdata;
        REG_NAME_HIGH: name_bytes_high <= pwdata;
        REG_NAME_LEN:  name_length <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_NAME_LOW:  prdata = name_bytes_low;
      REG_NAME_HIGH: prdata = name_bytes_high;
      REG_NAME_LEN:  prdata = {59'd0, name_length};
      default:       prdata = '0;
    endcase
  end

  assign len_use = (name_length > 5'(MAX_NAME_BYTES)) ? 5'(MAX_NAME_BYTES) : name_length;

  always_comb begin
    s0.phase = phase;
    s0.match_count = match_count;
    s0.recent = recent;
    s0.status = ST_IDLE;
    vc0 = value_count;
    if (s_tuser[0]) begin
      s0.phase = PH_SEARCH;
      s0.match_count = 5'd0;
      s0.recent = '0;
      vc0 = '0;
    end
    r = s0;
    value_count_next = vc0;
    vlen_src = '0;
    vbyte = 8'd0;
    case (s0.phase)
      PH_SEARCH: r = search_step(s0, b, {name_bytes_high, name_bytes_low}, len_use);
      PH_COLON, PH_COLON_END: begin
        r = colon_step(s0, b, {name_bytes_high, name_bytes_low}, len_use);
      end
      PH_SPACE, PH_SPACE_END: begin
        r = space_step(s0, b, {name_bytes_high, name_bytes_low}, len_use);
        if (r.phase == PH_VALUE) value_count_next = '0;
      end
      PH_VALUE: begin
        if ((b == CH_CR) || (b == CH_NUL)) begin
          r.phase = PH_DONE;
          r.status = ST_COMPLETE;
          vlen_src = vc0;
        end else begin
          // length saturates at all ones
          value_count_next = (vc0 == '1) ? vc0 : vc0 + LENGTH_BITS'(1);
          r.status = ST_BYTE;
          vbyte = b;
          vlen_src = value_count_next;
        end
      end
      default: r.phase = PH_DONE;
    endcase
    vlen_wide = LW'(vlen_src);
    vlen = (vlen_wide > LW'(16'hFFFF)) ? 16'hFFFF : vlen_wide[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEARCH;
      match_count <= 5'd0;
      recent <= '0;
      value_count <= '0;
    end else if (s_accept) begin
      phase <= r.phase;
      match_count <= r.match_count;
      recent <= r.recent;
      value_count <= value_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      m_tdata <= {vlen, vbyte};
      m_tuser <= r.status;
    end
  end

  `ASSERT_IMPLY(a_byte_has_length, m_tvalid && (m_tuser == ST_BYTE), m_tdata[23:8] != 16'd0, "value byte with zero length")
  `ASSERT_IMPLY(a_byte_only_with_value, m_tvalid && (m_tuser != ST_BYTE), m_tdata[7:0] == 8'd0, "value byte outside value")
  `ASSERT_NEXT(a_done_sticks, s_accept && (phase == PH_DONE) && !s_tuser[0], phase == PH_DONE, "left done without start")
  `ASSERT_IMPLY(a_count_in_value, value_count != '0, (phase == PH_VALUE) || (phase == PH_DONE), "value count outside value")

endmodule

// ===== dv/http_header_value_extractor_tb.sv =====
// self-checking testbench for the http header value extractor
module http_header_value_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hhve_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 200;
  localparam int LONG_VALUE  = 300;

  typedef struct packed {
    status_t     status;
    logic [7:0]  vbyte;
    logic [15:0] vlen;
  } value_result_t;

  class hhve_scoreboard;
    logic [63:0] name_lo;
    logic [63:0] name_hi;
    logic [4:0]  name_len;
    phase_t      cur_phase;
    logic [4:0]  match_cnt;
    logic [31:0] recent;
    logic [15:0] value_cnt;
    value_result_t pending_values[$];
    int errors;

    function new();
      name_lo = '0;
      name_hi = '0;
      name_len = 5'd1;
      cur_phase = PH_SEARCH;
      match_cnt = '0;
      recent = '0;
      value_cnt = '0;
      errors = 0;
    endfunction

    function void fail(string msg);
      errors++;
      $display("%0t ns: %s", $time, msg);
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] v);
      case (idx)
        REG_NAME_LOW:  name_lo = v;
        REG_NAME_HIGH: name_hi = v;
        REG_NAME_LEN:  name_len = v[4:0];
        default: ;
      endcase
    endfunction

    function void check_reg(logic [1:0] idx, logic [63:0] got);
      logic [63:0] want;
      case (idx)
        REG_NAME_LOW:  want = name_lo;
        REG_NAME_HIGH: want = name_hi;
        default:       want = {59'd0, name_len};
      endcase
      if (got !== want)
        fail($sformatf("register %0d readback expected %h actual %h", idx, want, got));
    endfunction

    function logic [7:0] name_at(int i);
      logic [127:0] full;
      full = {name_hi, name_lo};
      return full[i*8 +: 8];
    endfunction

    // naive matcher: a mismatching byte is not retried as a first name byte
    function status_t scan(logic [7:0] b);
      int len;
      len = (name_len > 5'd16) ? 16 : int'(name_len);
      if (b == CH_NUL) begin
        cur_phase = PH_DONE;
        return ST_NOTFOUND;
      end
      recent = {recent[23:0], b};
      if (match_cnt < len && b == name_at(int'(match_cnt[3:0]))) begin
        match_cnt++;
        if (match_cnt == len) begin
          match_cnt = '0;
          cur_phase = (recent == BLANK_LINE) ? PH_COLON_END : PH_COLON;
          return ST_IDLE;
        end
      end else begin
        match_cnt = '0;
      end
      if (recent == BLANK_LINE) begin
        cur_phase = PH_DONE;
        return ST_NOTFOUND;
      end
      return ST_IDLE;
    endfunction

    function status_t after_name(logic [7:0] b);
      logic at_end;
      at_end = (cur_phase == PH_COLON_END);
      if (b == CH_COLON) begin
        cur_phase = at_end ? PH_SPACE_END : PH_SPACE;
        return ST_IDLE;
      end
      if (at_end) begin
        cur_phase = PH_DONE;
        return ST_NOTFOUND;
      end
      cur_phase = PH_SEARCH;
      return scan(b);
    endfunction

    // missing space: the held colon goes back through the search first
    function status_t after_colon(logic [7:0] b);
      status_t st;
      if (b == CH_SPACE) begin
        cur_phase = PH_VALUE;
        value_cnt = '0;
        return ST_IDLE;
      end
      if (cur_phase == PH_SPACE_END) begin
        cur_phase = PH_DONE;
        return ST_NOTFOUND;
      end
      cur_phase = PH_SEARCH;
      st = scan(CH_COLON);
      if (cur_phase == PH_DONE) return st;
      if (cur_phase == PH_COLON || cur_phase == PH_COLON_END) return after_name(b);
      return scan(b);
    endfunction

    function void note_request(logic [7:0] b, logic sop);
      value_result_t r;
      r.status = ST_IDLE;
      r.vbyte = '0;
      r.vlen = '0;
      if (sop) begin
        cur_phase = PH_SEARCH;
        match_cnt = '0;
        recent = '0;
        value_cnt = '0;
      end
      case (cur_phase)
        PH_SEARCH: r.status = scan(b);
        PH_COLON, PH_COLON_END: r.status = after_name(b);
        PH_SPACE, PH_SPACE_END: r.status = after_colon(b);
        PH_VALUE: begin
          if (b == CH_CR || b == CH_NUL) begin
            r.status = ST_COMPLETE;
            r.vlen = value_cnt;
            cur_phase = PH_DONE;
          end else begin
            if (value_cnt != 16'hFFFF) value_cnt++;
            r.status = ST_BYTE;
            r.vbyte = b;
            r.vlen = value_cnt;
          end
        end
        default: cur_phase = PH_DONE;
      endcase
      pending_values.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [7:0] vb, logic [15:0] vl);
      value_result_t want;
      if (pending_values.size() == 0) begin
        fail($sformatf("result with no request waiting: status %0d byte %h length %0d",
                       st, vb, vl));
        return;
      end
      want = pending_values.pop_front();
      if (st !== want.status)
        fail($sformatf("status expected %0d actual %0d", want.status, st));
      if (vb !== want.vbyte)
        fail($sformatf("value_byte expected %h actual %h", want.vbyte, vb));
      if (vl !== want.vlen)
        fail($sformatf("value_length expected %0d actual %0d", want.vlen, vl));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // data_byte[7:0]
  logic [0:0]  s_tuser = '0;   // start_of_request[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // value_byte[7:0], value_length[23:8]
  logic [1:0]  m_tuser;        // status[1:0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  hhve_scoreboard board;
  logic [8:0]     stim_q[$];    // {start_of_request, data_byte}
  logic [7:0]     name_chars[16];
  int             name_used = 1;
  bit             no_idle = 1'b0;
  int             quiet = 0;

  http_header_value_extractor dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_result(m_tuser, m_tdata[7:0], m_tdata[23:8]);
    m_tready <= no_idle || ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [63:0] wdata,
                            output logic [63:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 3'b000};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [63:0] v);
    logic [63:0] got;
    apb_access(1'b1, idx, v, got);
    board.write_reg(idx, v);
    apb_access(1'b0, idx, 64'd0, got);
    board.check_reg(idx, got);
  endtask

  task automatic set_length(input logic [4:0] len);
    write_cfg(REG_NAME_LEN, {59'd0, len});
    name_used = (len > 5'd16) ? 16 : int'(len);
  endtask

  task automatic load_name(input logic [63:0] lo, input logic [63:0] hi, input logic [4:0] len);
    write_cfg(REG_NAME_LOW, lo);
    write_cfg(REG_NAME_HIGH, hi);
    set_length(len);
    for (int i = 0; i < 8; i++) begin
      name_chars[i] = lo[i*8 +: 8];
      name_chars[i+8] = hi[i*8 +: 8];
    end
  endtask

  task automatic send_byte(input logic [8:0] item);
    while (!no_idle && $urandom_range(99) < 26) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= item[7:0];
    s_tuser <= item[8];
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_request(item[7:0], item[8]);
  endtask

  task automatic play();
    while (stim_q.size() != 0) send_byte(stim_q.pop_front());
  endtask

  // registers change only with no request in flight
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending_values.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic void add_byte(logic [7:0] b, logic sop);
    stim_q.push_back({sop, b});
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
  endfunction

  function automatic void add_target(int cnt);
    for (int i = 0; i < cnt; i++) add_byte(name_chars[i], 1'b0);
  endfunction

  function automatic void add_value(int n);
    for (int i = 0; i < n; i++)
      add_byte(($urandom_range(3) == 0) ? 8'($urandom_range(1, 255))
                                        : 8'($urandom_range(33, 126)), 1'b0);
  endfunction

  // half of the bytes are name bytes so partial matches are common
  function automatic logic [7:0] text_char();
    if (name_used > 0 && $urandom_range(1) == 1) return name_chars[$urandom_range(name_used - 1)];
    return 8'($urandom_range(33, 126));
  endfunction

  function automatic logic [63:0] letters8();
    logic [63:0] w;
    for (int i = 0; i < 8; i++) w[i*8 +: 8] = 8'($urandom_range(97, 104));
    return w;
  endfunction

  function automatic void add_request();
    int kind;
    if ($urandom_range(9) == 0) begin
      // raw noise, with an occasional restart in the middle
      add_byte(8'($urandom_range(255)), 1'b1);
      repeat ($urandom_range(3, 19)) add_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
      return;
    end
    add_byte(text_char(), 1'b1);
    repeat ($urandom_range(2, 7)) add_byte(text_char(), 1'b0);
    add_text("\r\n");
    repeat ($urandom_range(1, 4)) begin
      kind = $urandom_range(9);
      case (kind)
        0, 1, 2, 3: begin
          add_target(name_used);
          add_text(": ");
          add_value($urandom_range(12));
        end
        4: begin
          add_target(name_used);
          add_byte(CH_COLON, 1'b0);
          add_value($urandom_range(1, 6));
        end
        5: begin
          add_target(name_used);
          add_value($urandom_range(1, 6));
        end
        6: begin
          add_target($urandom_range(name_used));
          add_text(": ");
          add_value($urandom_range(1, 6));
        end
        7: begin
          repeat ($urandom_range(1, 6)) add_byte(text_char(), 1'b0);
          add_text(": ");
          add_value($urandom_range(1, 6));
        end
        8: begin
          add_target(name_used);
          add_text(": ");
          add_value(3);
          add_byte(CH_NUL, 1'b0);
          add_value(2);
        end
        default: repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)), 1'b0);
      endcase
      add_text("\r\n");
    end
    if ($urandom_range(4) != 0) add_text("\r\n");
    repeat ($urandom_range(2)) add_byte(text_char(), 1'b0);
  endfunction

  initial begin
    int ph;
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // name "ab": value with extreme bytes, bytes after the end, nul, missing space
    load_name(64'h6261, 64'd0, 5'd2);
    add_byte("a", 1'b1);
    add_text("b: ");
    add_byte(8'hFF, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(CH_CR, 1'b0);
    add_byte("a", 1'b0);
    add_byte(CH_NUL, 1'b1);
    add_byte("a", 1'b1);
    add_text("b:ab: ");
    add_byte(8'h7F, 1'b0);
    add_byte(CH_NUL, 1'b0);
    add_byte("a", 1'b1);
    play();
    drain();
    // length shrinks below the bytes already matched
    set_length(5'd1);
    add_text("aa:x");
    play();
    drain();
    // name completes on the byte that closes a blank line
    load_name(64'h0A, 64'd0, 5'd1);
    add_byte(CH_CR, 1'b1);
    add_text("\n\r\n: z\r");
    play();
    drain();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_name({56'd0, 8'($urandom_range(97, 104))}, 64'd0, 5'd1);
        1: load_name(letters8(), letters8(), 5'd16);
        2: load_name(letters8(), letters8(), 5'd0);
        3: load_name(letters8(), letters8(), 5'd31);
        4: load_name('1, '1, 5'd16);
        5: load_name(letters8(), letters8(), 5'($urandom_range(2, 15)));
        6: load_name({$urandom, $urandom}, {$urandom, $urandom}, 5'($urandom_range(1, 16)));
        default: load_name(64'h0A, 64'd0, 5'd1);
      endcase
      no_idle = (ph == 5);
      while (stim_q.size() < PHASE_ITEMS) add_request();
      play();
      drain();
    end

    // one long value
    load_name(64'h6261, 64'd0, 5'd2);
    add_byte("a", 1'b1);
    add_text("b: ");
    repeat (LONG_VALUE) add_byte(8'($urandom_range(33, 126)), 1'b0);
    add_byte(CH_CR, 1'b0);
    add_byte("x", 1'b0);
    play();
    drain();

    repeat (4) @(posedge clk);
    if (board.errors == 0 && board.pending_values.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
